/* design/wct_pkg.sv */
//------------------------------------------------------------------------------
// wct_pkg
// Shared types and codes for the warp criticality tracker.
//------------------------------------------------------------------------------
package wct_pkg;

    typedef enum logic [1:0] {
        OP_DECODE = 2'd0,
        OP_COMMIT = 2'd1,
        OP_ISSUE  = 2'd2,
        OP_SPAWN  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  warp;
        logic [7:0]  pending_delta;
        logic        divergent;
        logic [1:0]  slot;
        logic        issued_valid;
        logic [1:0]  issued_lane;
        logic [47:0] now_cycle;
    } req_t;

    typedef struct packed {
        logic [3:0]  score_warp;
        logic [63:0] score;
        logic        last;
    } rsp_t;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

/* design/wct_div.sv */
//------------------------------------------------------------------------------
// wct_div
// Radix-2 restoring divider: 49-bit dividend by 32-bit divisor, one quotient
// bit per cycle.
//------------------------------------------------------------------------------
module wct_div
    import wct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [48:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [48:0] quotient
);

    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] rem_reg;
    logic [48:0] quo_reg;
    logic [31:0] dsr_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    // shift in next dividend bit, try subtract
    assign shifted = {rem_reg[31:0], quo_reg[48]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                if (!trial[32]) begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[47:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[47:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd48) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;

endmodule

/* design/warp_criticality_tracker_core.sv */
//------------------------------------------------------------------------------
// warp_criticality_tracker_core
// Per-warp criticality scores for a warp scheduler.
//------------------------------------------------------------------------------
// Usage: requests enter on s_valid/s_ready with a req_t payload; results leave
// on m_valid/m_ready as rsp_t, one per refreshed warp, last set on the final
// one. Decode, commit and spawn give one result; an issue-cycle request gives
// one result per warp of the slot. Invalid warp, invalid slot and zero-delta
// decode give none.
// Sequence: each score refresh runs a divider start step, the shared divider,
// a low and a high multiply step and an add step. Decode and commit first
// pass an accept step and a counter update step. An issue cycle for a live,
// non-issued warp refreshes twice, with a counter update step between. A
// spawn result follows its accept and counter update steps.
// One request is worked at a time; s_ready is low while a request is in work
// or its results are not all taken. A stalled receiver holds the result
// register and the sequencer waits. Reset clears all warp state at once
// (flip-flop arrays) and leaves the block idle and ready.
//------------------------------------------------------------------------------
module warp_criticality_tracker_core
    import wct_pkg::*;
#(
    parameter int WARP_COUNT  = 16,
    parameter int ISSUE_SLOTS = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    localparam int WW = (WARP_COUNT > 1) ? $clog2(WARP_COUNT) : 1;
    localparam int WC = $clog2(WARP_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_START, S_DIV_WAIT, S_MUL, S_MUL_HI, S_ADD, S_STALL, S_OUT
    } state_t;

    state_t       state_reg;
    req_t         req_reg;
    logic [WC-1:0] wid_reg;
    logic [WW-1:0] lane_reg;
    logic         second_reg;
    logic [56:0]  lo_reg;
    logic [63:0]  prod_reg;
    logic [48:0]  ratio_reg;
    logic         m_valid_reg;
    rsp_t         m_rsp_reg;

    logic [31:0] pend_mem [WARP_COUNT];
    logic [31:0] stall_mem[WARP_COUNT];
    logic [31:0] comm_mem [WARP_COUNT];
    logic [47:0] spawn_mem[WARP_COUNT];
    logic [63:0] score_mem[WARP_COUNT];

    logic [WW-1:0] wi;
    logic [48:0]   elapsed;
    logic          div_start;
    logic          div_done;
    logic [48:0]   div_q;
    logic [48:0]   ratio_fix;
    logic [24:0]   mul_a;
    logic [56:0]   mul_p;
    logic [81:0]   prod_full;
    logic [64:0]   sum;
    logic          live;
    logic          is_last;

    assign wi = wid_reg[WW-1:0];

    // elapsed cycles since spawn plus one (one if now is before spawn)
    always_comb begin
        if (req_reg.now_cycle >= spawn_mem[wi]) begin
            elapsed = {1'b0, req_reg.now_cycle - spawn_mem[wi]} + 49'd1;
        end else begin
            elapsed = 49'd1;
        end
    end

    assign div_start = (state_reg == S_DIV_START);

    wct_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (comm_mem[wi]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        if (comm_mem[wi] == 32'd0 || div_q == 49'd0) begin
            ratio_fix = 49'd1;
        end else begin
            ratio_fix = div_q;
        end
    end

    // shared 25x32 multiplier: low ratio half, then high ratio half
    assign mul_a     = (state_reg == S_MUL_HI) ? {1'b0, ratio_reg[48:25]} : ratio_reg[24:0];
    assign mul_p     = 57'(mul_a) * 57'(pend_mem[wi]);
    assign prod_full = {mul_p, 25'd0} + {25'd0, lo_reg};

    assign sum  = {1'b0, prod_reg} + {33'd0, stall_mem[wi]};
    assign live = (comm_mem[wi] != 32'd0) &&
                  !(req_reg.issued_valid && 32'(lane_reg) == 32'(req_reg.issued_lane));
    assign is_last = (req_reg.op != OP_ISSUE) ||
                     (32'(wid_reg) + 32'(ISSUE_SLOTS) >= 32'(WARP_COUNT));

    // sequencer, warp state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < WARP_COUNT; i++) begin
                pend_mem[i]  <= '0;
                stall_mem[i] <= '0;
                comm_mem[i]  <= '0;
                spawn_mem[i] <= '0;
                score_mem[i] <= '0;
            end
        end else begin
            // result valid set on a new result, cleared when taken
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg    <= s_req;
                        second_reg <= 1'b0;
                        lane_reg   <= '0;
                        if (s_req.op == OP_ISSUE) begin
                            wid_reg <= WC'(s_req.slot);
                            if (32'(s_req.slot) < 32'(ISSUE_SLOTS) &&
                                32'(s_req.slot) < 32'(WARP_COUNT)) begin
                                state_reg <= S_DIV_START;
                            end
                        end else begin
                            wid_reg <= WC'(s_req.warp);
                            if (32'(s_req.warp) < 32'(WARP_COUNT)) begin
                                if (s_req.op == OP_SPAWN) begin
                                    state_reg <= S_STALL;
                                end else if (s_req.op == OP_DECODE) begin
                                    if (s_req.pending_delta != 8'd0) begin
                                        state_reg <= S_STALL;
                                    end
                                end else begin
                                    state_reg <= S_STALL;
                                end
                            end
                        end
                    end
                end
                S_STALL: begin
                    // counter update for decode, commit, spawn and issue stall
                    state_reg <= (req_reg.op == OP_SPAWN) ? S_OUT : S_DIV_START;
                    case (req_reg.op)
                        OP_DECODE: begin
                            if (pend_mem[wi] > MAX32 - 32'(req_reg.pending_delta)) begin
                                pend_mem[wi] <= MAX32;
                            end else begin
                                pend_mem[wi] <= pend_mem[wi] + 32'(req_reg.pending_delta);
                            end
                        end
                        OP_COMMIT: begin
                            if (comm_mem[wi] != MAX32) comm_mem[wi] <= comm_mem[wi] + 32'd1;
                            if (!req_reg.divergent && pend_mem[wi] != 32'd0) begin
                                pend_mem[wi] <= pend_mem[wi] - 32'd1;
                            end
                        end
                        OP_SPAWN: begin
                            pend_mem[wi]  <= '0;
                            stall_mem[wi] <= '0;
                            comm_mem[wi]  <= '0;
                            score_mem[wi] <= '0;
                            spawn_mem[wi] <= req_reg.now_cycle;
                        end
                        default: begin
                            if (stall_mem[wi] != MAX32) stall_mem[wi] <= stall_mem[wi] + 32'd1;
                            second_reg <= 1'b1;
                        end
                    endcase
                end
                S_DIV_START: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        ratio_reg <= ratio_fix;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    lo_reg    <= mul_p;
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    prod_reg  <= (prod_full[81:64] != 18'd0) ? MAX64 : prod_full[63:0];
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    score_mem[wi] <= sum[64] ? MAX64 : sum[63:0];
                    if (req_reg.op == OP_ISSUE && !second_reg && live) begin
                        state_reg <= S_STALL;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_rsp_reg.score_warp <= 4'(wid_reg);
                        m_rsp_reg.score      <= score_mem[wi];
                        m_rsp_reg.last       <= is_last;
                        if (is_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            wid_reg    <= wid_reg + WC'(ISSUE_SLOTS);
                            lane_reg   <= lane_reg + WW'(1);
                            second_reg <= 1'b0;
                            state_reg  <= S_DIV_START;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

`ifndef SYNTH
    // no request taken while busy
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready while busy");
    // divider finishes only while waited on
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV_WAIT) else $error("stray divider done");
    // result held under stall
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp)) else $error("result dropped");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Checks the warp criticality tracker against a behavioral score predictor.
// Directed requests cover each event kind, clock extremes and a zero-delta decode;
// random requests follow, with bursty sending and a stalling receiver.
//------------------------------------------------------------------------------
module tb;
    import wct_pkg::*;

    localparam int N_WARPS   = 16;
    localparam int N_SLOTS   = 4;
    localparam int WDOG_MAX  = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;

    warp_criticality_tracker_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state per warp
    logic [31:0] pend_q  [N_WARPS];
    logic [31:0] stall_q [N_WARPS];
    logic [31:0] cmt_q   [N_WARPS];
    logic [47:0] spawn_q [N_WARPS];
    logic [63:0] crit_q  [N_WARPS];

    rsp_t score_exp_q[$];
    int   n_errors = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;
    bit   gap_enable = 1'b1;
    bit   stall_enable = 1'b1;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // append one expected result
    task automatic queue_expected(input rsp_t e);
        score_exp_q = {score_exp_q, e};
    endtask

    function automatic logic [63:0] calc_score(input int w, input logic [47:0] now);
        logic [63:0] elapsed;
        logic [63:0] ratio;
        logic [127:0] prod;
        logic [64:0] sum;
        elapsed = 64'd1;
        ratio = 64'd1;
        if (now >= spawn_q[w]) elapsed = 64'(now - spawn_q[w]) + 64'd1;
        if (cmt_q[w] != 0) begin
            ratio = elapsed / 64'(cmt_q[w]);
            if (ratio == 0) ratio = 64'd1;
        end
        prod = 128'(pend_q[w]) * 128'(ratio);
        if (prod > 128'(MAX64)) prod = 128'(MAX64);
        sum = 65'(prod[63:0]) + 65'(stall_q[w]);
        return sum[64] ? MAX64 : sum[63:0];
    endfunction

    // work out expected results for one accepted request
    task automatic predict_scores(input req_t r);
        int n0;
        int lane;
        n0 = score_exp_q.size();
        if (r.op == OP_ISSUE) begin
            if (r.slot >= N_SLOTS) return;
            lane = 0;
            for (int w = r.slot; w < N_WARPS; w += N_SLOTS) begin
                crit_q[w] = calc_score(w, r.now_cycle);
                if (!(r.issued_valid && lane == r.issued_lane) && cmt_q[w] > 0) begin
                    if (stall_q[w] != MAX32) stall_q[w]++;
                    crit_q[w] = calc_score(w, r.now_cycle);
                end
                queue_expected(rsp_t'{score_warp: 4'(w), score: crit_q[w], last: 1'b0});
                lane++;
            end
        end else begin
            if (r.warp >= N_WARPS) return;
            case (r.op)
                OP_DECODE: begin
                    if (r.pending_delta == 0) return;
                    if (pend_q[r.warp] > MAX32 - 32'(r.pending_delta)) pend_q[r.warp] = MAX32;
                    else pend_q[r.warp] += 32'(r.pending_delta);
                    crit_q[r.warp] = calc_score(r.warp, r.now_cycle);
                end
                OP_COMMIT: begin
                    if (cmt_q[r.warp] != MAX32) cmt_q[r.warp]++;
                    if (!r.divergent && pend_q[r.warp] != 0) pend_q[r.warp]--;
                    crit_q[r.warp] = calc_score(r.warp, r.now_cycle);
                end
                default: begin
                    pend_q[r.warp] = '0;
                    stall_q[r.warp] = '0;
                    cmt_q[r.warp] = '0;
                    crit_q[r.warp] = '0;
                    spawn_q[r.warp] = r.now_cycle;
                end
            endcase
            queue_expected(rsp_t'{score_warp: r.warp, score: crit_q[r.warp], last: 1'b0});
        end
        if (score_exp_q.size() > n0) score_exp_q[$].last = 1'b1;
    endtask

    // send one request, with random gaps between bursts
    task automatic send_request(input req_t r);
        int gap;
        if (gap_enable && burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_req <= r;
        do @(posedge aclk); while (!s_ready);
        predict_scores(r);
    endtask

    function automatic req_t make_req(input op_t op, input int w, input int delta,
                                      input logic [47:0] now);
        req_t r;
        r = '0;
        r.op = op;
        r.warp = 4'(w);
        r.pending_delta = 8'(delta);
        r.now_cycle = now;
        return r;
    endfunction

    function automatic req_t rand_req(input bit noise);
        req_t r;
        int sel;
        r.op = 2'($urandom_range(0, 3));
        r.warp = 4'($urandom_range(0, 15));
        r.pending_delta = $urandom_range(0, 7) == 0 ? 8'hFF : 8'($urandom);
        r.divergent = 1'($urandom);
        r.slot = 2'($urandom);
        r.issued_valid = 1'($urandom);
        r.issued_lane = 2'($urandom);
        sel = $urandom_range(0, 9);
        r.now_cycle = sel == 0 ? 48'hFFFF_FFFF_FFFF : sel == 1 ? 48'({$urandom, $urandom})
                      : 48'($urandom_range(0, 5000));
        if (!noise && r.op == OP_DECODE && r.pending_delta == 0) r.pending_delta = 8'd1;
        return r;
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (score_exp_q.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic test_basic_events();
        send_request(make_req(OP_SPAWN, 0, 0, 48'd100));
        send_request(make_req(OP_DECODE, 0, 255, 48'd105));
        send_request(make_req(OP_DECODE, 0, 0, 48'd106));
        send_request(make_req(OP_COMMIT, 0, 0, 48'd110));
        begin
            req_t r;
            r = make_req(OP_COMMIT, 0, 0, 48'd200);
            r.divergent = 1'b1;
            send_request(r);
        end
        send_request(make_req(OP_COMMIT, 5, 0, 48'd3));
        send_request(make_req(OP_COMMIT, 5, 0, 48'd4));
    endtask

    task automatic test_issue_cycles();
        req_t r;
        for (int s = 0; s < N_SLOTS; s++) begin
            r = make_req(OP_ISSUE, 0, 0, 48'd300 + 48'(s));
            r.slot = 2'(s);
            r.issued_valid = 1'(s & 1);
            r.issued_lane = 2'(3 - s);
            send_request(r);
        end
    endtask

    task automatic test_clock_extremes();
        send_request(make_req(OP_SPAWN, 15, 0, 48'hFFFF_FFFF_FFFF));
        send_request(make_req(OP_DECODE, 15, 200, 48'd1));
        send_request(make_req(OP_COMMIT, 15, 0, 48'd0));
        send_request(make_req(OP_DECODE, 1, 255, 48'hFFFF_FFFF_FFFF));
        send_request(make_req(OP_COMMIT, 1, 0, 48'hFFFF_FFFF_FFFF));
        send_request(make_req(OP_DECODE, 1, 128, 48'hAAAA_5555_AAAA));
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 260; i++) begin
            if (i == 130) gap_enable = 1'b0;
            if (i == 200) begin
                gap_enable = 1'b1;
                stall_enable = 1'b0;
            end
            send_request(rand_req($urandom_range(0, 9) == 0));
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !stall_enable || ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (score_exp_q.size() == 0) begin
                report_mismatch("unexpected result warp", 64'(m_rsp.score_warp), 64'd0);
            end else begin
                rsp_t e;
                e = score_exp_q.pop_front();
                if (m_rsp.score_warp !== e.score_warp)
                    report_mismatch("score_warp", 64'(m_rsp.score_warp), 64'(e.score_warp));
                if (m_rsp.score !== e.score)
                    report_mismatch("score", m_rsp.score, e.score);
                if (m_rsp.last !== e.last)
                    report_mismatch("last", 64'(m_rsp.last), 64'(e.last));
            end
        end
    end

    // watchdog on cycles without progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        for (int w = 0; w < N_WARPS; w++) begin
            pend_q[w] = '0;
            stall_q[w] = '0;
            cmt_q[w] = '0;
            spawn_q[w] = '0;
            crit_q[w] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_events();
        test_issue_cycles();
        test_clock_extremes();
        test_random_traffic();
        wait_drained();
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/wct_pkg.sv
design/wct_div.sv
design/warp_criticality_tracker_core.sv
tb/sv/tb.sv
